FILE: design/bccu_pkg.sv
// Package: shared types, constants and helpers for the button click/hold classifier.
`timescale 1ns / 1ps
package bccu_pkg;

    localparam int CntW = 8;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 8;

    localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

    localparam logic [CntW-1:0] ShortHoldLimitRst = CntW'(7);
    localparam logic [CntW-1:0] LongHoldLimitRst  = CntW'(10);
    localparam logic [CntW-1:0] ReleaseTimeoutRst = CntW'(5);

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SHORT_HOLD_LIMIT = 2'd0,
        CFG_LONG_HOLD_LIMIT  = 2'd1,
        CFG_RELEASE_TIMEOUT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic            event_valid;
        logic            long_press;
        logic [CntW-1:0] click_count;
    } t_result;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        sat_inc = (v == CntMax) ? v : v + CntW'(1);
    endfunction

endpackage

FILE: design/bccu_if.sv
// Interfaces: input level channel and result channel.
`timescale 1ns / 1ps
interface bccu_in_if;
    logic valid;
    logic ready;
    logic button_level;

    modport source (output valid, output button_level, input ready);
    modport sink (input valid, input button_level, output ready);
endinterface

interface bccu_out_if;
    logic                      valid;
    logic                      ready;
    logic                      event_valid;
    logic                      long_press;
    logic [bccu_pkg::CntW-1:0] click_count;

    modport source (output valid, output event_valid, output long_press,
                    output click_count, input ready);
    modport sink (input valid, input event_valid, input long_press,
                  input click_count, output ready);
endinterface

FILE: design/bccu_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
module bccu_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bccu_pkg::t_result i_data,
    output logic              o_ready,
    output logic              o_valid,
    output bccu_pkg::t_result o_data,
    input  logic              i_pop_ready
);

    logic              r_v0, n_v0;
    logic              r_v1, n_v1;
    bccu_pkg::t_result r_d0, n_d0;
    bccu_pkg::t_result r_d1, n_d1;
    logic              w_push;
    logic              w_pop;

    assign o_ready = !r_v1;
    assign o_valid = r_v0;
    assign o_data  = r_d0;
    assign w_push  = i_push && !r_v1;
    assign w_pop   = r_v0 && i_pop_ready;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_d0 = r_d0;
        n_d1 = r_d1;
        if (!r_v0 || w_pop) begin
            if (r_v1) begin
                n_v0 = 1'b1;
                n_d0 = r_d1;
                n_v1 = 1'b0;
            end else begin
                n_v0 = w_push;
                n_d0 = i_data;
            end
        end else if (w_push) begin
            n_v1 = 1'b1;
            n_d1 = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

endmodule

FILE: design/button_click_hold_classifier_unit.sv
// Top level: button click / long-press classifier with config port and output buffer.
// Each item's result is registered in the output buffer (output or skid register).
// Throughput: one item per cycle unless the buffer is full; state update is one pass.
// A two-entry output buffer keeps input accepts going while one result waits.
// Reset (synchronous, active low) restores the default limits, clears all counters,
// sets the previous level to released and empties the output buffer.
`timescale 1ns / 1ps
module button_click_hold_classifier_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bccu_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [bccu_pkg::CfgDataW-1:0] i_cfg_data,
    bccu_in_if.sink                       i_in,
    bccu_out_if.source                    o_out
);

    localparam int W = bccu_pkg::CntW;

    logic [W-1:0] r_short_lim;
    logic [W-1:0] r_long_lim;
    logic [W-1:0] r_rel_to;

    logic         r_prev_level, n_prev_level;
    logic [W-1:0] r_press_cnt,  n_press_cnt;
    logic [W-1:0] r_hold_cnt,   n_hold_cnt;
    logic [W-1:0] r_rel_cnt,    n_rel_cnt;
    logic         r_click_pend, n_click_pend;

    logic              w_accept;
    logic              w_ready;
    logic              w_event;
    logic              w_long;
    bccu_pkg::t_result w_res;
    bccu_pkg::t_result w_out;

    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_lim <= bccu_pkg::ShortHoldLimitRst;
            r_long_lim  <= bccu_pkg::LongHoldLimitRst;
            r_rel_to    <= bccu_pkg::ReleaseTimeoutRst;
        end else if (i_cfg_we) begin
            unique case (bccu_pkg::t_cfg_idx'(i_cfg_idx))
                bccu_pkg::CFG_SHORT_HOLD_LIMIT: r_short_lim <= i_cfg_data[W-1:0];
                bccu_pkg::CFG_LONG_HOLD_LIMIT:  r_long_lim  <= i_cfg_data[W-1:0];
                bccu_pkg::CFG_RELEASE_TIMEOUT:  r_rel_to    <= i_cfg_data[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_prev_level = i_in.button_level;
        n_press_cnt  = r_press_cnt;
        n_hold_cnt   = r_hold_cnt;
        n_rel_cnt    = r_rel_cnt;
        n_click_pend = r_click_pend;
        w_event      = 1'b0;
        w_long       = 1'b0;
        if (!i_in.button_level) begin
            if (r_prev_level) begin
                n_press_cnt = bccu_pkg::sat_inc(r_press_cnt);
            end
            if (r_hold_cnt < r_short_lim) begin
                n_click_pend = 1'b1;
            end else if (r_hold_cnt > r_long_lim) begin
                w_event      = 1'b1;
                w_long       = 1'b1;
                n_click_pend = 1'b0;
                n_press_cnt  = '0;
            end
            n_rel_cnt  = '0;
            n_hold_cnt = bccu_pkg::sat_inc(r_hold_cnt);
        end else begin
            if (r_rel_cnt >= r_rel_to && r_click_pend) begin
                w_event      = 1'b1;
                n_click_pend = 1'b0;
            end
            n_hold_cnt = '0;
        end
        if (n_click_pend) begin
            n_rel_cnt = bccu_pkg::sat_inc(n_rel_cnt);
        end
        w_res.event_valid = w_event;
        w_res.long_press  = w_long;
        w_res.click_count = (w_event && !w_long) ? n_press_cnt : '0;
        if (w_event) begin
            n_press_cnt = '0;
            n_rel_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b1;
            r_press_cnt  <= '0;
            r_hold_cnt   <= '0;
            r_rel_cnt    <= '0;
            r_click_pend <= 1'b0;
        end else if (w_accept) begin
            r_prev_level <= n_prev_level;
            r_press_cnt  <= n_press_cnt;
            r_hold_cnt   <= n_hold_cnt;
            r_rel_cnt    <= n_rel_cnt;
            r_click_pend <= n_click_pend;
        end
    end

    bccu_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_in.valid),
        .i_data      (w_res),
        .o_ready     (w_ready),
        .o_valid     (o_out.valid),
        .o_data      (w_out),
        .i_pop_ready (o_out.ready)
    );

    assign o_out.event_valid = w_out.event_valid;
    assign o_out.long_press  = w_out.long_press;
    assign o_out.click_count = w_out.click_count;

endmodule

FILE: dv/button_click_hold_classifier_unit_tb.sv
// Testbench: predicts the button classifier result per item and checks it on the output channel.
`timescale 1ns / 1ps
module button_click_hold_classifier_unit_tb;

    localparam logic [bccu_pkg::CfgIdxW-1:0] CfgIdxUnused = 2'd3;
    localparam logic [8:0]                   LongMark     = 9'h100;
    localparam int                           CycleLimit   = 200000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [bccu_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [bccu_pkg::CfgDataW-1:0] i_cfg_data;

    bccu_in_if  in_if ();
    bccu_out_if out_if ();

    button_click_hold_classifier_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // predictor state and limits
    logic [bccu_pkg::CntW-1:0] cfg_short;
    logic [bccu_pkg::CntW-1:0] cfg_long;
    logic [bccu_pkg::CntW-1:0] cfg_timeout;
    logic                      m_prev;
    logic [bccu_pkg::CntW-1:0] m_press;
    logic [bccu_pkg::CntW-1:0] m_hold;
    logic [bccu_pkg::CntW-1:0] m_rel;
    logic                      m_click;
    logic                      m_event;
    logic [8:0]                m_code;

    bccu_pkg::t_result expected_q[$];
    bccu_pkg::t_result want;
    bccu_pkg::t_result got;

    bit stall_en = 1'b1;
    int items_sent;
    int events_seen;
    int long_seen;
    int cfg_writes;
    int fail_count;
    int cycle_count;

    function automatic logic [bccu_pkg::CntW-1:0] bump_sat(
        input logic [bccu_pkg::CntW-1:0] v);
        return (v == bccu_pkg::CntMax) ? v : v + bccu_pkg::CntW'(1);
    endfunction

    function automatic bccu_pkg::t_result classify_level(input logic lvl);
        bccu_pkg::t_result r;
        if (!lvl) begin
            if (m_prev) m_press = bump_sat(m_press);
            if (m_hold < cfg_short) begin
                m_click = 1'b1;
            end else if (m_hold > cfg_long) begin
                m_code  = LongMark;
                m_event = 1'b1;
                m_click = 1'b0;
                m_press = '0;
            end
            m_rel  = '0;
            m_hold = bump_sat(m_hold);
        end else begin
            if (m_rel >= cfg_timeout && m_click) begin
                m_event = 1'b1;
                m_click = 1'b0;
            end
            m_hold = '0;
        end
        if (m_click) m_rel = bump_sat(m_rel);
        if (m_event) begin
            if (m_press != '0) m_code = {1'b0, m_press};
            m_press = '0;
            m_rel   = '0;
        end
        m_prev = lvl;
        r = '0;
        if (m_event) begin
            r.event_valid = 1'b1;
            r.long_press  = m_code[8];
            r.click_count = m_code[7:0];
            m_event = 1'b0;
            m_code  = '0;
        end
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        if (fail_count < 10) $display("ERROR: %s", msg);
        fail_count++;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= !stall_en || ($urandom_range(0, 99) >= 7);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = {out_if.event_valid, out_if.long_press, out_if.click_count};
            if (expected_q.size() == 0) begin
                note_failure($sformatf("result with nothing expected: ev=%0b long=%0b count=%0d",
                                       got.event_valid, got.long_press, got.click_count));
            end else begin
                want = expected_q.pop_front();
                if (got.event_valid !== want.event_valid || got.long_press !== want.long_press
                        || got.click_count !== want.click_count) begin
                    note_failure($sformatf(
                        "mismatch: exp ev=%0b long=%0b count=%0d, got ev=%0b long=%0b count=%0d",
                        want.event_valid, want.long_press, want.click_count,
                        got.event_valid, got.long_press, got.click_count));
                end
                if (want.event_valid) events_seen++;
                if (want.long_press) long_seen++;
            end
        end
    end

    task automatic send_level(input logic lvl);
        @(negedge i_clk);
        while (stall_en && $urandom_range(0, 99) < 7) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.button_level <= lvl;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_q.push_back(classify_level(lvl));
        items_sent++;
    endtask

    task automatic send_run(input logic lvl, input int len);
        repeat (len) send_level(lvl);
    endtask

    // drop valid and wait until every expected result has been checked
    task automatic settle_block();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [bccu_pkg::CfgIdxW-1:0] idx,
                             input logic [bccu_pkg::CfgDataW-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bccu_pkg::CFG_SHORT_HOLD_LIMIT: cfg_short   = val;
            bccu_pkg::CFG_LONG_HOLD_LIMIT:  cfg_long    = val;
            bccu_pkg::CFG_RELEASE_TIMEOUT:  cfg_timeout = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_limits(input int s, input int l, input int t);
        settle_block();
        write_reg(bccu_pkg::CFG_SHORT_HOLD_LIMIT, bccu_pkg::CfgDataW'(s));
        write_reg(bccu_pkg::CFG_LONG_HOLD_LIMIT, bccu_pkg::CfgDataW'(l));
        write_reg(bccu_pkg::CFG_RELEASE_TIMEOUT, bccu_pkg::CfgDataW'(t));
    endtask

    task automatic test_click_bursts();
        send_run(1'b0, 2);
        send_run(1'b1, 7);
        send_run(1'b0, 1);
        send_run(1'b1, 2);
        send_run(1'b0, 3);
        send_run(1'b1, 7);
    endtask

    task automatic test_long_press();
        send_run(1'b0, 14);
        send_run(1'b1, 3);
    endtask

    // long press, then raise both limits while still held: clicks pend with no press counted
    task automatic test_zero_count_click();
        send_run(1'b0, 12);
        settle_block();
        write_reg(bccu_pkg::CFG_SHORT_HOLD_LIMIT, 8'd255);
        write_reg(bccu_pkg::CFG_LONG_HOLD_LIMIT, 8'd255);
        send_run(1'b0, 1);
        send_run(1'b1, 7);
        set_limits(bccu_pkg::ShortHoldLimitRst, bccu_pkg::LongHoldLimitRst,
                   bccu_pkg::ReleaseTimeoutRst);
    endtask

    task automatic test_zero_timeout();
        set_limits(7, 10, 0);
        send_run(1'b0, 1);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        send_run(1'b1, 1);
    endtask

    task automatic test_unknown_index();
        set_limits(bccu_pkg::ShortHoldLimitRst, bccu_pkg::LongHoldLimitRst,
                   bccu_pkg::ReleaseTimeoutRst);
        write_reg(CfgIdxUnused, 8'h00);
        send_run(1'b0, 2);
        send_run(1'b1, 7);
    endtask

    // press and hold counters run into 255; single releases stay under the timeout
    task automatic test_saturation();
        set_limits(255, 255, 2);
        repeat (256) begin
            send_level(1'b0);
            send_level(1'b1);
        end
        send_run(1'b1, 3);
        send_run(1'b0, 256);
        send_run(1'b1, 3);
    endtask

    task automatic run_gestures(input int n_items);
        int stop_at;
        int kind;
        int clicks;
        int span;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                clicks = $urandom_range(1, 4);
                for (int k = 0; k < clicks; k++) begin
                    send_run(1'b0, $urandom_range(1, int'(cfg_short) + 2));
                    if (k == clicks - 1) span = int'(cfg_timeout) + $urandom_range(1, 3);
                    else span = $urandom_range(1, int'(cfg_timeout) + 1);
                    send_run(1'b1, span);
                end
            end else if (kind < 92) begin
                send_run(1'b0, int'(cfg_long) + $urandom_range(1, 6));
                send_run(1'b1, int'(cfg_timeout) + 2);
            end else begin
                span = $urandom_range(1, 8);
                repeat (span) send_level(1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_random();
        int s;
        int l;
        set_limits(7, 10, 5);
        run_gestures(40);
        set_limits(0, 0, 0);
        run_gestures(25);
        repeat (3) begin
            s = $urandom_range(1, 8);
            l = $urandom_range(s, 12);
            set_limits(s, l, $urandom_range(0, 6));
            run_gestures(20);
        end
        set_limits(9, 3, 2);
        run_gestures(20);
        stall_en = 1'b0;
        set_limits(4, 6, 3);
        run_gestures(80);
        settle_block();
        stall_en = 1'b1;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        in_if.valid        = 1'b0;
        in_if.button_level = 1'b1;
        cfg_short   = bccu_pkg::ShortHoldLimitRst;
        cfg_long    = bccu_pkg::LongHoldLimitRst;
        cfg_timeout = bccu_pkg::ReleaseTimeoutRst;
        m_prev  = 1'b1;
        m_press = '0;
        m_hold  = '0;
        m_rel   = '0;
        m_click = 1'b0;
        m_event = 1'b0;
        m_code  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_click_bursts();
        test_long_press();
        test_zero_count_click();
        test_zero_timeout();
        test_unknown_index();
        test_saturation();
        test_random();

        settle_block();
        repeat (5) @(negedge i_clk);
        if (expected_q.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_q.size()));
        $display("Covered %0d button samples and %0d register writes, with saturation runs",
                 items_sent, cfg_writes);
        $display("Events checked: %0d, of them %0d long presses; %0d failures",
                 events_seen, long_seen, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
